// ===== hw/rtl/clam_pkg.sv =====
// ----------------------------------------------------------------------------
// clam_pkg
// Shared widths, types and helpers of the contrastive loss unit.
// ----------------------------------------------------------------------------
package clam_pkg;

    localparam int EMB_W        = 16;
    localparam int LABEL_W      = 16;
    localparam int SQ_W         = 32;
    localparam int DIST_W       = 48;
    localparam int ROOT_W       = 24;
    localparam int MARGIN_W     = 26;
    localparam int LEGACY_SHIFT = 13;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // One sorted entry: pair distance and its similar flag.
    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic              sim;
    } pair_key_t;

    // Operation applied to every cell of the sorting row.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_op_t;

    // Sort order: by distance, dissimilar ahead of similar on ties.
    function automatic logic key_less(input pair_key_t x, input pair_key_t y);
        logic res;
        if (x.dval != y.dval)
        begin
            res = (x.dval < y.dval);
        end
        else
        begin
            res = !x.sim && y.sim;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/clam_ifs.sv =====
// ----------------------------------------------------------------------------
// clam_ifs
// Handshake channels of the contrastive loss unit.
// ----------------------------------------------------------------------------
interface clam_item_if;
    logic                                valid;
    logic                                ready;
    logic signed [clam_pkg::EMB_W-1:0]   emb_a;
    logic signed [clam_pkg::EMB_W-1:0]   emb_b;
    logic        [clam_pkg::LABEL_W-1:0] label_a;
    logic        [clam_pkg::LABEL_W-1:0] label_b;
    logic                                last_channel;
    logic                                last_pair;

    modport source (output valid, emb_a, emb_b, label_a, label_b, last_channel,
                    last_pair, input ready);
    modport sink (input valid, emb_a, emb_b, label_a, label_b, last_channel,
                  last_pair, output ready);
endinterface

interface clam_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [clam_pkg::MARGIN_W-1:0]        margin;
    logic [clam_pkg::DIST_W-1:0]          loss;
    logic                                 overflow;

    modport source (output valid, margin, loss, overflow, input ready);
    modport sink (input valid, margin, loss, overflow, output ready);
endinterface

interface clam_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/contrastive_loss_adaptive_margin_unit.sv =====
// ----------------------------------------------------------------------------
// contrastive_loss_adaptive_margin_unit
// Contrastive loss over a batch of embedding pairs with an adaptive margin.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  item     in   emb_a, emb_b, label_a, label_b, last_channel, last_pair
//  cfg      in   legacy_mode bit
//  result   out  margin, loss, overflow
//
// Embedding items are taken one per cycle while a batch streams in; each
// closed pair is placed at once into a sorted row of MAX_PAIRS cells,
// unless the row is full. After the closing item the unit drains the input
// pipeline, rotates the row for the threshold scan, takes the margin root,
// then for each pair adds a term (similar or legacy pairs directly, others
// after the root of the distance and a square), divides and loads the output.
// Input is held off during that time, and a result still waiting on the
// output holds the unit until it is taken. Reset clears all control state.
// ----------------------------------------------------------------------------
module contrastive_loss_adaptive_margin_unit #(
    parameter int MAX_PAIRS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    clam_item_if.sink     item,
    clam_cfg_if.sink      cfg,
    clam_result_if.source result
);

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int EW = CW + 1;
    localparam int DW = CW + 1;

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b0000_0000_0001,
        ST_WAIT_CLOSE = 12'b0000_0000_0010,
        ST_SCAN       = 12'b0000_0000_0100,
        ST_ROOT_GO    = 12'b0000_0000_1000,
        ST_ROOT_WAIT  = 12'b0000_0001_0000,
        ST_LOSS_RD    = 12'b0000_0010_0000,
        ST_LOSS_SQ    = 12'b0000_0100_0000,
        ST_LOSS_MUL   = 12'b0000_1000_0000,
        ST_LOSS_ADD   = 12'b0001_0000_0000,
        ST_DIV_GO     = 12'b0010_0000_0000,
        ST_DIV_WAIT   = 12'b0100_0000_0000,
        ST_DONE       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic legacy_reg;

    // Input pipeline.
    logic                         take;
    logic signed [clam_pkg::EMB_W:0] diff;
    logic [clam_pkg::EMB_W:0]     adiff;
    logic                         s1_valid_reg;
    logic [clam_pkg::SQ_W-1:0]    s1_sq_reg;
    logic                         s1_lc_reg, s1_lp_reg, s1_sim_reg;
    logic [clam_pkg::DIST_W-1:0]  acc_reg, acc_next;
    logic [clam_pkg::DIST_W:0]    acc_sum;
    logic [clam_pkg::DIST_W-1:0]  acc_sat;
    logic                         p_valid_reg, p_close_reg;
    clam_pkg::pair_key_t          p_key_reg;
    logic                         ins;

    // Batch bookkeeping and sequencer registers.
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic                         sat_reg, sat_next;
    logic signed [EW-1:0]         err_reg, err_next, min_reg, min_next;
    logic signed [EW-1:0]         err_cur, min_cur, err_new;
    logic [clam_pkg::DIST_W-1:0]  thr_reg, thr_next, thr_cur;
    logic [clam_pkg::ROOT_W-1:0]  margin_reg, margin_next;
    logic [clam_pkg::ROOT_W-1:0]  h_reg, h_next;
    logic [clam_pkg::DIST_W-1:0]  term_reg, term_next;
    logic [clam_pkg::DIST_W-1:0]  sum_reg, sum_next;
    logic [clam_pkg::DIST_W:0]    loss_sum;
    logic [clam_pkg::DIST_W-1:0]  m_al;
    logic                         uniform;
    logic                         load_out;

    // Output register.
    logic                         out_valid_reg;
    logic [clam_pkg::MARGIN_W-1:0] out_margin_reg;
    logic [clam_pkg::DIST_W-1:0]  out_loss_reg;
    logic                         out_ovf_reg;

    // Shared units.
    logic                         sq_start, sq_busy, sq_done;
    logic [clam_pkg::DIST_W-1:0]  sq_val;
    logic [clam_pkg::ROOT_W-1:0]  sq_root;
    logic                         div_start, div_done;
    logic [clam_pkg::DIST_W-1:0]  div_quot;

    // Sorting row.
    clam_pkg::cell_op_t           cell_op;
    logic                         rotate;
    clam_pkg::pair_key_t          cell_key   [MAX_PAIRS];
    logic                         cell_valid [MAX_PAIRS];
    logic                         cell_less  [MAX_PAIRS];

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            legacy_reg <= cfg.data;
        end
    end

    // Stage 1: squared element difference.
    assign item.ready = (state_reg == ST_IDLE);
    assign take       = item.valid && item.ready;

    always_comb
    begin
        diff  = {item.emb_a[clam_pkg::EMB_W-1], item.emb_a}
              - {item.emb_b[clam_pkg::EMB_W-1], item.emb_b};
        adiff = diff[clam_pkg::EMB_W] ? (clam_pkg::EMB_W + 1)'(-diff)
                                      : (clam_pkg::EMB_W + 1)'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            p_valid_reg  <= s1_valid_reg && s1_lc_reg;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sq_reg  <= clam_pkg::SQ_W'(adiff[clam_pkg::EMB_W-1:0])
                        * clam_pkg::SQ_W'(adiff[clam_pkg::EMB_W-1:0]);
            s1_lc_reg  <= item.last_channel;
            s1_lp_reg  <= item.last_pair;
            s1_sim_reg <= (item.label_a == item.label_b);
        end
        if (s1_valid_reg && s1_lc_reg)
        begin
            p_key_reg.dval <= acc_sat;
            p_key_reg.sim  <= s1_sim_reg;
            p_close_reg    <= s1_lp_reg;
        end
    end

    // Stage 2: saturating distance accumulation.
    always_comb
    begin
        acc_sum  = {1'b0, acc_reg} + (clam_pkg::DIST_W + 1)'(s1_sq_reg);
        acc_sat  = acc_sum[clam_pkg::DIST_W] ? clam_pkg::DIST_SAT
                                             : acc_sum[clam_pkg::DIST_W-1:0];
        acc_next = acc_reg;
        if (s1_valid_reg)
        begin
            acc_next = s1_lc_reg ? '0 : acc_sat;
        end
    end

    // Stage 3: a closed pair enters the row unless the row is full.
    assign ins = p_valid_reg && (count_reg < CW'(MAX_PAIRS));

    // Row of sorting cells; a shift moves every key one slot toward slot 0.
    for (genvar k = 0; k < MAX_PAIRS; k++)
    begin : g_cell
        clam_pkg::pair_key_t lkey;
        logic                lvalid;
        logic                lless;
        clam_pkg::pair_key_t rkey;
        logic                rvalid;

        if (k == 0)
        begin : g_first
            assign lkey   = p_key_reg;
            assign lvalid = 1'b1;
            assign lless  = 1'b0;
        end
        else
        begin : g_inner
            assign lkey   = cell_key[k-1];
            assign lvalid = cell_valid[k-1];
            assign lless  = cell_less[k-1];
        end

        if (k == MAX_PAIRS - 1)
        begin : g_last
            assign rkey   = cell_key[0];
            assign rvalid = rotate && cell_valid[0];
        end
        else
        begin : g_mid
            assign rkey   = cell_key[k+1];
            assign rvalid = cell_valid[k+1];
        end

        clam_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (cell_op),
            .new_key     (p_key_reg),
            .left_key    (lkey),
            .left_valid  (lvalid),
            .left_less   (lless),
            .right_key   (rkey),
            .right_valid (rvalid),
            .key         (cell_key[k]),
            .valid       (cell_valid[k]),
            .less        (cell_less[k])
        );
    end

    clam_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_val),
        .busy  (sq_busy),
        .done  (sq_done),
        .root  (sq_root)
    );

    clam_div #(
        .DIV_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  ({count_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Scan and loss sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        err_next    = err_reg;
        min_next    = min_reg;
        thr_next    = thr_reg;
        margin_next = margin_reg;
        h_next      = h_reg;
        term_next   = term_reg;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        cell_op     = clam_pkg::CELL_HOLD;
        rotate      = 1'b0;
        sq_start    = 1'b0;
        sq_val      = thr_reg;
        div_start   = 1'b0;
        load_out    = 1'b0;

        uniform  = (pos_reg == '0) || (pos_reg == count_reg);
        err_cur  = (idx_reg == '0) ? EW'(pos_reg) : err_reg;
        min_cur  = (idx_reg == '0) ? EW'(pos_reg) : min_reg;
        thr_cur  = (idx_reg == '0) ? '0 : thr_reg;
        err_new  = cell_key[0].sim ? err_cur - EW'(1) : err_cur + EW'(1);
        m_al     = clam_pkg::DIST_W'({margin_reg, {clam_pkg::LEGACY_SHIFT{1'b0}}});
        loss_sum = {1'b0, sum_reg} + {1'b0, term_reg};

        if (s1_valid_reg && acc_sum[clam_pkg::DIST_W])
        begin
            sat_next = 1'b1;
        end

        if (ins)
        begin
            cell_op    = clam_pkg::CELL_INSERT;
            count_next = count_reg + 1'b1;
            pos_next   = pos_reg + CW'(p_key_reg.sim);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && item.last_channel && item.last_pair)
                begin
                    state_next = ST_WAIT_CLOSE;
                end
            end
            ST_WAIT_CLOSE:
            begin
                if (p_valid_reg && p_close_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cell_op  = clam_pkg::CELL_SHIFT;
                rotate   = 1'b1;
                err_next = err_cur;
                min_next = min_cur;
                thr_next = thr_cur;
                if (idx_reg < count_reg)
                begin
                    err_next = err_new;
                    if (uniform)
                    begin
                        thr_next = cell_key[0].dval;
                    end
                    else if (err_new < min_cur)
                    begin
                        min_next = err_new;
                        thr_next = cell_key[0].dval;
                    end
                end
                if (idx_reg == CW'(MAX_PAIRS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_ROOT_GO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ROOT_GO:
            begin
                sq_start   = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sq_done)
                begin
                    margin_next = sq_root;
                    sum_next    = '0;
                    state_next  = ST_LOSS_RD;
                end
            end
            ST_LOSS_RD:
            begin
                cell_op = clam_pkg::CELL_SHIFT;
                sq_val  = cell_key[0].dval;
                if (cell_key[0].sim)
                begin
                    term_next  = cell_key[0].dval;
                    state_next = ST_LOSS_ADD;
                end
                else if (legacy_reg)
                begin
                    term_next  = (m_al > cell_key[0].dval) ? m_al - cell_key[0].dval : '0;
                    state_next = ST_LOSS_ADD;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = ST_LOSS_SQ;
                end
            end
            ST_LOSS_SQ:
            begin
                if (sq_done)
                begin
                    h_next     = (margin_reg > sq_root) ? margin_reg - sq_root : '0;
                    state_next = ST_LOSS_MUL;
                end
            end
            ST_LOSS_MUL:
            begin
                term_next  = clam_pkg::DIST_W'(h_reg) * clam_pkg::DIST_W'(h_reg);
                state_next = ST_LOSS_ADD;
            end
            ST_LOSS_ADD:
            begin
                if (loss_sum[clam_pkg::DIST_W])
                begin
                    sum_next = clam_pkg::DIST_SAT;
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = loss_sum[clam_pkg::DIST_W-1:0];
                end
                if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LOSS_RD;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    cell_op    = clam_pkg::CELL_CLEAR;
                    count_next = '0;
                    pos_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            sat_reg   <= sat_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        min_reg    <= min_next;
        thr_reg    <= thr_next;
        margin_reg <= margin_next;
        h_reg      <= h_next;
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        if (load_out)
        begin
            out_margin_reg <= clam_pkg::MARGIN_W'(margin_reg);
            out_loss_reg   <= div_quot;
            out_ovf_reg    <= sat_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.margin   = out_margin_reg;
    assign result.loss     = out_loss_reg;
    assign result.overflow = out_ovf_reg;

    // The row never holds more pairs than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PAIRS))
        else $error("pair count beyond row size");

    // Similar pairs are a subset of the stored pairs.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("similar count above pair count");

    // The root unit is idle whenever new items are taken.
    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !sq_busy)
        else $error("root unit busy in idle");

    // The divide never starts on an empty batch.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> count_reg != '0)
        else $error("divide by zero pair count");

endmodule

// ===== hw/rtl/clam_cell.sv =====
// ----------------------------------------------------------------------------
// clam_cell
// One slot of the sorting row: holds one pair key and trades with neighbors.
// ----------------------------------------------------------------------------
module clam_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  clam_pkg::cell_op_t  op,
    input  clam_pkg::pair_key_t new_key,
    input  clam_pkg::pair_key_t left_key,
    input  logic                left_valid,
    input  logic                left_less,
    input  clam_pkg::pair_key_t right_key,
    input  logic                right_valid,
    output clam_pkg::pair_key_t key,
    output logic                valid,
    output logic                less
);

    clam_pkg::pair_key_t key_reg;
    clam_pkg::pair_key_t key_next;
    logic                valid_reg;
    logic                valid_next;

    // The new key sorts ahead of this slot, or the slot is empty.
    assign less  = !valid_reg || clam_pkg::key_less(new_key, key_reg);
    assign key   = key_reg;
    assign valid = valid_reg;

    // Next content of the slot. An empty left neighbor hands on an empty slot.
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        unique case (op)
            clam_pkg::CELL_HOLD:
            begin
                key_next = key_reg;
            end
            clam_pkg::CELL_INSERT:
            begin
                if (left_less)
                begin
                    key_next   = left_key;
                    valid_next = left_valid;
                end
                else if (less)
                begin
                    key_next   = new_key;
                    valid_next = 1'b1;
                end
            end
            clam_pkg::CELL_SHIFT:
            begin
                key_next   = right_key;
                valid_next = right_valid;
            end
            clam_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== hw/rtl/clam_isqrt.sv =====
// ----------------------------------------------------------------------------
// clam_isqrt
// Integer square root of a distance, one result bit per cycle.
// ----------------------------------------------------------------------------
module clam_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clam_pkg::DIST_W-1:0]   value,
    output logic                          busy,
    output logic                          done,
    output logic [clam_pkg::ROOT_W-1:0]   root
);

    localparam int REM_W = clam_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(clam_pkg::ROOT_W);

    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [clam_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [clam_pkg::DIST_W-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [REM_W-1:0]                rem_sh;
    logic [REM_W-1:0]                trial;

    // Bring down two bits and try to set the next root bit.
    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], val_reg[clam_pkg::DIST_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            val_next  = value;
            cnt_next  = CNT_W'(clam_pkg::ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[clam_pkg::DIST_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[clam_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[clam_pkg::ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/clam_div.sv =====
// ----------------------------------------------------------------------------
// clam_div
// Restoring divider of the loss sum by twice the pair count.
// ----------------------------------------------------------------------------
module clam_div #(
    parameter int DIV_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [clam_pkg::DIST_W-1:0] dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [clam_pkg::DIST_W-1:0] quotient
);

    localparam int CNT_W = $clog2(clam_pkg::DIST_W);

    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [clam_pkg::DIST_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0]            dsr_reg, dsr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [DIV_W:0]              rem_sh;

    // One quotient bit per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[clam_pkg::DIST_W-1]};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(clam_pkg::DIST_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next  = DIV_W'(rem_sh - {1'b0, dsr_reg});
                quot_next = {quot_reg[clam_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DIV_W-1:0];
                quot_next = {quot_reg[clam_pkg::DIST_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
